// File: hw/rtl/gsuf_pkg.sv
package gsuf_pkg;

  localparam int unsigned NodeW   = 12;
  localparam int unsigned Nodes   = 1 << NodeW;
  localparam int unsigned RankW   = 4;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned WeightW = 16;
  localparam int unsigned KW      = 24;
  localparam int unsigned WeightFracBits = 15;

  localparam logic [KW-1:0]    KReset  = KW'(150 << WeightFracBits);
  localparam logic [KW-1:0]    ThrMax  = '1;
  localparam logic [SizeW-1:0] SizeMax = '1;
  localparam logic [RankW-1:0] RankMax = '1;

  localparam logic ActMerge = 1'b0;
  localparam logic ActFind  = 1'b1;

  // One input request.
  typedef struct packed {
    logic               action;
    logic [NodeW-1:0]   node_a;
    logic [NodeW-1:0]   node_b;
    logic [WeightW-1:0] weight;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [NodeW-1:0] root;
    logic             merged;
    logic             already_joined;
  } out_rsp_t;

  // One entry of the node store.
  typedef struct packed {
    logic [NodeW-1:0]   parent;
    logic [RankW-1:0]   rank;
    logic [SizeW-1:0]   size;
    logic [WeightW-1:0] diff;
  } node_entry_t;

endpackage

// File: hw/rtl/gsuf_mem.sv
// Node store: one write port and one read port with registered read data.
module gsuf_mem (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [gsuf_pkg::NodeW-1:0]    wr_addr_i,
  input  gsuf_pkg::node_entry_t         wr_data_i,
  input  logic [gsuf_pkg::NodeW-1:0]    rd_addr_i,
  output gsuf_pkg::node_entry_t         rd_data_o
);

  gsuf_pkg::node_entry_t mem_q [gsuf_pkg::Nodes];
  gsuf_pkg::node_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/gsuf_div.sv
// Restoring divider: one quotient bit per cycle, done pulses once the last quotient bit is in.
module gsuf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gsuf_pkg::KW-1:0]       dividend_i,
  input  logic [gsuf_pkg::SizeW-1:0]    divisor_i,
  output logic                          done_o,
  output logic [gsuf_pkg::KW-1:0]       quotient_o
);

  localparam int unsigned CntW = $clog2(gsuf_pkg::KW + 1);

  logic [gsuf_pkg::KW-1:0]    quo_q;
  logic [gsuf_pkg::SizeW-1:0] rem_q, div_q;
  logic [CntW-1:0]            cnt_q;
  logic                       done_q;
  logic [gsuf_pkg::SizeW:0]   shifted;
  logic                       fits;

  assign shifted = {rem_q, quo_q[gsuf_pkg::KW-1]};
  assign fits    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(gsuf_pkg::KW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath of the shift-subtract loop.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (fits) begin
        rem_q <= gsuf_pkg::SizeW'(shifted - {1'b0, div_q});
      end else begin
        rem_q <= shifted[gsuf_pkg::SizeW-1:0];
      end
      quo_q <= {quo_q[gsuf_pkg::KW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: hw/rtl/graph_segment_union_find.sv
// Union-find merge engine for graph segmentation. After reset the node store
// is cleared by a pass over all 4096 entries during which no request is taken.
// One request is handled at a time. A find request walks from the node to its
// root and walks the path again to point every node at the root, reading each
// visited node through the node store's single read port both ways. A merge
// request does this for both nodes; when both share a root it ends there.
// Otherwise it reads both root entries and runs two divisions of k by the
// component sizes on one shared divider; a rejected edge ends there, and a
// merged one writes two entries. A result that waits for the receiver does not
// hold off the next request, which is taken and handled; only its result then
// waits until the earlier one is taken.
module graph_segment_union_find (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gsuf_pkg::in_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gsuf_pkg::out_rsp_t                  out_rsp_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gsuf_pkg::KW-1:0]             cfg_k_value_i
);

  typedef enum logic [3:0] {
    StClear, StIdle, StFindRd, StFindChk, StCompRd, StCompChk,
    StRdA, StCapA, StRdB, StCapB, StDivA, StDivB, StWr1, StWr2, StOut
  } state_e;

  state_e                       state_q;
  logic [gsuf_pkg::NodeW-1:0]   clr_q;
  logic [gsuf_pkg::NodeW-1:0]   cur_q, rt_q, ra_q, rb_q;
  logic                         phase_q;
  gsuf_pkg::in_req_t            req_q;
  gsuf_pkg::node_entry_t        ea_q, eb_q;
  logic [gsuf_pkg::KW-1:0]      k_q, t1_q;
  gsuf_pkg::out_rsp_t           res_q, out_q;
  logic                         out_valid_q;

  logic                         wr_en;
  logic [gsuf_pkg::NodeW-1:0]   wr_addr;
  gsuf_pkg::node_entry_t        wr_data, rd_data;
  logic                         div_start, div_done;
  logic [gsuf_pkg::SizeW-1:0]   div_divisor, div_size;
  logic [gsuf_pkg::KW-1:0]      div_quo, thr_now, thr_min;
  logic [gsuf_pkg::KW:0]        thr_sum;
  logic                         a_low, do_merge;
  logic [gsuf_pkg::SizeW:0]     size_sum;
  logic [gsuf_pkg::SizeW-1:0]   size_new;
  logic [gsuf_pkg::RankW-1:0]   rank_inc;

  gsuf_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (cur_q),
    .rd_data_o (rd_data)
  );

  // Divider shared by both threshold computations.
  assign div_size    = (state_q == StCapB) ? ea_q.size : eb_q.size;
  assign div_divisor = (div_size == '0) ? gsuf_pkg::SizeW'(1) : div_size;
  assign div_start   = (state_q == StCapB) || (state_q == StDivA && div_done);

  gsuf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (k_q),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Saturated threshold and merge decision.
  always_comb begin
    thr_sum = {1'b0, div_quo} + (gsuf_pkg::KW + 1)'(
      (state_q == StDivA) ? ea_q.diff : eb_q.diff);
    thr_now = thr_sum[gsuf_pkg::KW] ? gsuf_pkg::ThrMax : thr_sum[gsuf_pkg::KW-1:0];
    thr_min = (t1_q < thr_now) ? t1_q : thr_now;
    do_merge = gsuf_pkg::KW'(req_q.weight) <= thr_min;
  end

  // Node store writes: the cleared entries, the path compression and, by union by rank, the entries of StWr1 and StWr2.
  always_comb begin
    a_low    = ea_q.rank < eb_q.rank;
    size_sum = {1'b0, ea_q.size} + {1'b0, eb_q.size};
    size_new = size_sum[gsuf_pkg::SizeW] ? gsuf_pkg::SizeMax
                                         : size_sum[gsuf_pkg::SizeW-1:0];
    rank_inc = ea_q.rank;
    if (ea_q.rank == eb_q.rank && ea_q.rank != gsuf_pkg::RankMax) begin
      rank_inc = ea_q.rank + 1'b1;
    end
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = rd_data;
    unique case (state_q)
      StClear: begin
        wr_en          = 1'b1;
        wr_addr        = clr_q;
        wr_data.parent = clr_q;
        wr_data.rank   = '0;
        wr_data.size   = gsuf_pkg::SizeW'(1);
        wr_data.diff   = '0;
      end
      StCompChk: begin
        wr_en          = rd_data.parent != cur_q;
        wr_data.parent = rt_q;
      end
      StWr1: begin
        wr_en = 1'b1;
        if (a_low) begin
          wr_addr        = ra_q;
          wr_data        = ea_q;
          wr_data.parent = rb_q;
        end else begin
          wr_addr        = rb_q;
          wr_data        = eb_q;
          wr_data.parent = ra_q;
        end
      end
      StWr2: begin
        wr_en = 1'b1;
        if (a_low) begin
          wr_addr = rb_q;
          wr_data = eb_q;
        end else begin
          wr_addr      = ra_q;
          wr_data      = ea_q;
          wr_data.rank = rank_inc;
        end
        wr_data.size = size_new;
        wr_data.diff = req_q.weight;
      end
      default: begin
      end
    endcase
  end

  // Sequencer with result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      k_q         <= gsuf_pkg::KReset;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        k_q <= cfg_k_value_i;
      end
      if (out_valid_q && out_ready_i && state_q != StOut) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_valid_i) begin
            req_q   <= in_req_i;
            cur_q   <= in_req_i.node_a;
            phase_q <= 1'b0;
            state_q <= StFindRd;
          end
        end
        StFindRd: state_q <= StFindChk;
        StFindChk: begin
          if (rd_data.parent == cur_q) begin
            rt_q    <= cur_q;
            cur_q   <= phase_q ? req_q.node_b : req_q.node_a;
            state_q <= StCompRd;
          end else begin
            cur_q   <= rd_data.parent;
            state_q <= StFindRd;
          end
        end
        StCompRd: state_q <= StCompChk;
        StCompChk: begin
          if (rd_data.parent == cur_q) begin
            res_q.merged <= 1'b0;
            if (!phase_q) begin
              res_q.root           <= rt_q;
              res_q.already_joined <= 1'b0;
              ra_q                 <= rt_q;
              if (req_q.action == gsuf_pkg::ActFind) begin
                state_q <= StOut;
              end else begin
                phase_q <= 1'b1;
                cur_q   <= req_q.node_b;
                state_q <= StFindRd;
              end
            end else begin
              // The result names the root of node_a in every merge outcome
              // but a successful merge, which overwrites it later with the surviving root.
              rb_q                 <= rt_q;
              res_q.root           <= ra_q;
              res_q.already_joined <= ra_q == rt_q;
              if (ra_q == rt_q) begin
                state_q <= StOut;
              end else begin
                cur_q   <= ra_q;
                state_q <= StRdA;
              end
            end
          end else begin
            cur_q   <= rd_data.parent;
            state_q <= StCompRd;
          end
        end
        StRdA: state_q <= StCapA;
        StCapA: begin
          ea_q    <= rd_data;
          cur_q   <= rb_q;
          state_q <= StRdB;
        end
        StRdB: state_q <= StCapB;
        StCapB: begin
          eb_q    <= rd_data;
          state_q <= StDivA;
        end
        StDivA: begin
          if (div_done) begin
            t1_q    <= thr_now;
            state_q <= StDivB;
          end
        end
        StDivB: begin
          if (div_done) begin
            state_q <= do_merge ? StWr1 : StOut;
          end
        end
        StWr1: state_q <= StWr2;
        StWr2: begin
          res_q.root   <= a_low ? rb_q : ra_q;
          res_q.merged <= 1'b1;
          state_q      <= StOut;
        end
        StOut: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: verif/gsuf_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and k register channels of the union-find
// engine, keeps its own copy of the node store and checks every result.
module gsuf_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  gsuf_pkg::in_req_t            in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  gsuf_pkg::out_rsp_t           out_rsp_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [gsuf_pkg::KW-1:0]      cfg_k_value_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           results_o,
  output int                           merges_o
);

  logic [gsuf_pkg::NodeW-1:0]   parent_mem [gsuf_pkg::Nodes];
  logic [gsuf_pkg::RankW-1:0]   rank_mem   [gsuf_pkg::Nodes];
  logic [gsuf_pkg::SizeW-1:0]   size_mem   [gsuf_pkg::Nodes];
  logic [gsuf_pkg::WeightW-1:0] diff_mem   [gsuf_pkg::Nodes];
  logic [gsuf_pkg::KW-1:0]      k_scale;
  gsuf_pkg::out_rsp_t           expected_rsps [$];

  assign pending_o = expected_rsps.size();

  // Finds the root of a node and points every node on the path at it.
  function automatic logic [gsuf_pkg::NodeW-1:0] find_and_compress(
      logic [gsuf_pkg::NodeW-1:0] node);
    logic [gsuf_pkg::NodeW-1:0] top;
    logic [gsuf_pkg::NodeW-1:0] nxt;
    int                         steps;
    top = node;
    steps = 0;
    while (parent_mem[top] != top && steps < gsuf_pkg::Nodes) begin
      top = parent_mem[top];
      steps++;
    end
    steps = 0;
    while (parent_mem[node] != node && steps < gsuf_pkg::Nodes) begin
      nxt = parent_mem[node];
      parent_mem[node] = top;
      node = nxt;
      steps++;
    end
    return top;
  endfunction

  // Internal difference plus k over the component size, saturated.
  function automatic logic [gsuf_pkg::KW-1:0] merge_limit(
      logic [gsuf_pkg::NodeW-1:0] r);
    logic [gsuf_pkg::SizeW-1:0] sz;
    logic [gsuf_pkg::KW:0]      sum;
    sz = (size_mem[r] == '0) ? gsuf_pkg::SizeW'(1) : size_mem[r];
    sum = (gsuf_pkg::KW+1)'(diff_mem[r]) + (gsuf_pkg::KW+1)'(k_scale / sz);
    return sum > (gsuf_pkg::KW+1)'(gsuf_pkg::ThrMax) ? gsuf_pkg::ThrMax
                                                     : sum[gsuf_pkg::KW-1:0];
  endfunction

  // Applies one accepted request to the node store and returns its result.
  function automatic gsuf_pkg::out_rsp_t apply_request(gsuf_pkg::in_req_t req);
    gsuf_pkg::out_rsp_t         rsp;
    logic [gsuf_pkg::NodeW-1:0] ra;
    logic [gsuf_pkg::NodeW-1:0] rb;
    logic [gsuf_pkg::KW-1:0]    la;
    logic [gsuf_pkg::KW-1:0]    lb;
    logic [gsuf_pkg::SizeW:0]   total;
    rsp = '0;
    if (req.action == gsuf_pkg::ActFind) begin
      rsp.root = find_and_compress(req.node_a);
    end else begin
      ra = find_and_compress(req.node_a);
      rb = find_and_compress(req.node_b);
      rsp.root = ra;
      if (ra == rb) begin
        rsp.already_joined = 1'b1;
      end else begin
        la = merge_limit(ra);
        lb = merge_limit(rb);
        if (gsuf_pkg::KW'(req.weight) <= ((la < lb) ? la : lb)) begin
          total = (gsuf_pkg::SizeW+1)'(size_mem[ra]) + (gsuf_pkg::SizeW+1)'(size_mem[rb]);
          if (rank_mem[ra] < rank_mem[rb]) begin
            parent_mem[ra] = rb;
            rsp.root = rb;
          end else begin
            parent_mem[rb] = ra;
            if (rank_mem[ra] == rank_mem[rb] && rank_mem[ra] != gsuf_pkg::RankMax) begin
              rank_mem[ra] = rank_mem[ra] + 1'b1;
            end
          end
          diff_mem[rsp.root] = req.weight;
          size_mem[rsp.root] = total > (gsuf_pkg::SizeW+1)'(gsuf_pkg::SizeMax)
                               ? gsuf_pkg::SizeMax : total[gsuf_pkg::SizeW-1:0];
          rsp.merged = 1'b1;
        end
      end
    end
    return rsp;
  endfunction

  // Tracks all three channels on each clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    gsuf_pkg::out_rsp_t exp_rsp;
    if (!rst_ni) begin
      for (int i = 0; i < gsuf_pkg::Nodes; i++) begin
        parent_mem[i] = gsuf_pkg::NodeW'(i);
        rank_mem[i] = '0;
        size_mem[i] = gsuf_pkg::SizeW'(1);
        diff_mem[i] = '0;
      end
      k_scale = gsuf_pkg::KReset;
      expected_rsps.delete();
      fail_count_o = 0;
      results_o = 0;
      merges_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        k_scale = cfg_k_value_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_rsps = {expected_rsps, apply_request(in_req_i)};
      end
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (out_rsp_i.merged) merges_o++;
        if (expected_rsps.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result root=%0d merged=%0b joined=%0b", $time,
                   out_rsp_i.root, out_rsp_i.merged, out_rsp_i.already_joined);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (exp_rsp.root != out_rsp_i.root) begin
            fail_count_o++;
            $display("%0t: root expected %0d actual %0d", $time,
                     exp_rsp.root, out_rsp_i.root);
          end
          if (exp_rsp.merged != out_rsp_i.merged) begin
            fail_count_o++;
            $display("%0t: merged expected %0b actual %0b", $time,
                     exp_rsp.merged, out_rsp_i.merged);
          end
          if (exp_rsp.already_joined != out_rsp_i.already_joined) begin
            fail_count_o++;
            $display("%0t: already_joined expected %0b actual %0b", $time,
                     exp_rsp.already_joined, out_rsp_i.already_joined);
          end
        end
      end
    end
  end

endmodule

// File: verif/graph_segment_union_find_tb.sv
`timescale 1ns / 1ps

module graph_segment_union_find_tb;

  localparam int CycleLimit = 3000000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  gsuf_pkg::in_req_t            in_req_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  gsuf_pkg::out_rsp_t           out_rsp_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [gsuf_pkg::KW-1:0]      cfg_k_value_i = '0;

  int fail_count;
  int pending;
  int results;
  int merges;
  int cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int requests_sent = 0;
  logic [gsuf_pkg::WeightW-1:0] edge_weight;

  graph_segment_union_find u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_req_i,
    .out_valid_o,
    .out_ready_i,
    .out_rsp_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_k_value_i
  );

  gsuf_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .in_req_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .out_rsp_i    (out_rsp_o),
    .cfg_valid_i,
    .cfg_ready_i  (cfg_ready_o),
    .cfg_k_value_i,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .merges_o     (merges)
  );

  always #6 clk_i = ~clk_i;

  // Receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("graph_segment_union_find regression: fail");
      $finish;
    end
  end

  // Presents one request, idling first if the phase asks for it.
  task automatic send_request(logic act, logic [gsuf_pkg::NodeW-1:0] a,
                              logic [gsuf_pkg::NodeW-1:0] b,
                              logic [gsuf_pkg::WeightW-1:0] w);
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{action: act, node_a: a, node_b: b, weight: w};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Drains the engine, then loads a new k.
  task automatic load_k(logic [gsuf_pkg::KW-1:0] k);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_k_value_i <= k;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly ascending edges inside a small neighborhood, plus finds and noise.
  task automatic run_random(int count);
    logic [gsuf_pkg::NodeW-1:0] base;
    int                         pick;
    base = gsuf_pkg::NodeW'($urandom);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (i % 40 == 0) base = gsuf_pkg::NodeW'($urandom);
      if (pick < 75) begin
        if (edge_weight < 16'd32000) begin
          edge_weight = edge_weight + gsuf_pkg::WeightW'($urandom_range(0, 300));
        end
        send_request(gsuf_pkg::ActMerge, base + gsuf_pkg::NodeW'($urandom_range(0, 47)),
                     base + gsuf_pkg::NodeW'($urandom_range(0, 47)), edge_weight);
      end else if (pick < 88) begin
        send_request(gsuf_pkg::ActFind, base + gsuf_pkg::NodeW'($urandom_range(0, 47)),
                     gsuf_pkg::NodeW'($urandom), gsuf_pkg::WeightW'($urandom));
      end else begin
        send_request(logic'($urandom), gsuf_pkg::NodeW'($urandom),
                     gsuf_pkg::NodeW'($urandom), gsuf_pkg::WeightW'($urandom));
      end
    end
  endtask

  initial begin
    edge_weight = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks at the reset value of k.
    send_request(gsuf_pkg::ActFind, '0, '0, '0);
    send_request(gsuf_pkg::ActFind, '1, '1, '1);
    send_request(gsuf_pkg::ActMerge, 12'd5, 12'd5, 16'd0);
    send_request(gsuf_pkg::ActMerge, 12'd0, 12'd1, 16'd0);
    send_request(gsuf_pkg::ActMerge, 12'd1, 12'd0, 16'd10);
    send_request(gsuf_pkg::ActMerge, 12'd2, 12'd3, 16'd32768);
    send_request(gsuf_pkg::ActMerge, 12'd0, 12'd2, 16'd32768);
    send_request(gsuf_pkg::ActFind, 12'd3, '0, '0);
    send_request(gsuf_pkg::ActMerge, '1, 12'd4094, 16'hFFFF);
    send_request(gsuf_pkg::ActMerge, 12'd4093, 12'hAAA, 16'h5555);
    send_request(gsuf_pkg::ActMerge, 12'h555, 12'hAAA, 16'hAAAA);

    // Zero k: only zero weights can join fresh nodes.
    load_k('0);
    send_request(gsuf_pkg::ActMerge, 12'd100, 12'd101, 16'd1);
    send_request(gsuf_pkg::ActMerge, 12'd100, 12'd101, 16'd0);
    send_request(gsuf_pkg::ActMerge, 12'd102, 12'd100, 16'd0);
    send_request(gsuf_pkg::ActMerge, 12'd103, 12'd101, 16'd1);

    // Largest k: the limit sum does not saturate, as a root that holds a difference also holds a size above one.
    load_k('1);
    send_request(gsuf_pkg::ActMerge, 12'd200, 12'd201, 16'hFFFF);
    send_request(gsuf_pkg::ActMerge, 12'd202, 12'd200, 16'hFFFF);
    send_request(gsuf_pkg::ActFind, 12'd201, '0, '0);
    run_random(100);

    load_k(24'd1000);
    sender_idle_pct = 48;
    edge_weight = '0;
    run_random(100);

    load_k(gsuf_pkg::KReset);
    sender_idle_pct = 0;
    receiver_stall_pct = 48;
    edge_weight = '0;
    run_random(100);

    load_k(gsuf_pkg::KW'($urandom_range(0, 200000)));
    sender_idle_pct = 37;
    receiver_stall_pct = 37;
    edge_weight = '0;
    run_random(100);

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_random(100);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d requests over five k settings and four idle patterns.",
             requests_sent);
    $display("Checked %0d results, %0d of them merges.", results, merges);
    if (fail_count == 0) begin
      $display("graph_segment_union_find regression: pass");
    end else begin
      $display("graph_segment_union_find regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/gsuf_pkg.sv
hw/rtl/gsuf_mem.sv
hw/rtl/gsuf_div.sv
hw/rtl/graph_segment_union_find.sv
verif/gsuf_checker.sv
verif/graph_segment_union_find_tb.sv
